// ===== rtl/asss_pkg.sv =====
`timescale 1ns / 1ps

package asss_pkg;

    // default sizing of the search core
    localparam int MAX_PATTERN_DEF   = 31;
    localparam int MAX_ERRORS_DEF    = 7;
    localparam int ALPHABET_DEF      = 256;
    localparam int POSITION_BITS_DEF = 16;

    // fixed field widths
    localparam int CHAR_W    = 8;
    localparam int INDEX_W   = 5;
    localparam int LENGTH_W  = 5;
    localparam int LIMIT_W   = 3;
    localparam int START_W   = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 5;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_START = 2'd2,
        OP_TEXT  = 2'd3
    } op_t;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_LIMIT    = 1'd1;

endpackage

// ===== rtl/asss_ram.sv =====
`timescale 1ns / 1ps

module asss_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/approximate_shift_and_search_unit.sv =====
`timescale 1ns / 1ps
// clear-table and start-text requests finish in the accept cycle
// a pattern-byte load goes through accept, table read and read-modify-write
// a text byte goes through accept, table read, mask merge, the level walk and finish to a registered result,
// and no new request is taken until it is done: one shared level unit walks the vectors one a cycle
// reset clears control, config, position and vectors; the mask table reads as all ones
// through per-entry valid bits, so no clearing pass is needed

module approximate_shift_and_search_unit #(
    parameter int MAX_PATTERN   = asss_pkg::MAX_PATTERN_DEF,
    parameter int MAX_ERRORS    = asss_pkg::MAX_ERRORS_DEF,
    parameter int ALPHABET      = asss_pkg::ALPHABET_DEF,
    parameter int POSITION_BITS = asss_pkg::POSITION_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [asss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [asss_pkg::CFG_DAT_W-1:0]  cfg_data,

    input  logic                            req_valid,
    output logic                            req_ready,
    input  logic [1:0]                      op,
    input  logic [asss_pkg::CHAR_W-1:0]     char_value,
    input  logic [asss_pkg::INDEX_W-1:0]    pattern_index,

    output logic                            res_valid,
    input  logic                            res_ready,
    output logic                            match_found,
    output logic [asss_pkg::START_W-1:0]    start_position,
    output logic                            first_match_res
);

    localparam int TW  = MAX_PATTERN;
    localparam int VW  = MAX_PATTERN + 1;
    localparam int NL  = MAX_ERRORS + 1;
    localparam int LW  = $clog2(NL);
    localparam int AW  = $clog2(ALPHABET);
    localparam int PW  = POSITION_BITS;
    localparam int PW1 = POSITION_BITS + 1;
    localparam int SW  = (POSITION_BITS > asss_pkg::START_W) ? POSITION_BITS : asss_pkg::START_W;

    localparam logic [VW-1:0] VEC_INIT = {{(VW-1){1'b1}}, 1'b0};
    localparam logic [PW-1:0] POS_MAX  = '1;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_LOOK   = 5'b00010,
        ST_MERGE  = 5'b00100,
        ST_LEVEL  = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [asss_pkg::LENGTH_W-1:0] pattern_length_reg;
    logic [asss_pkg::LIMIT_W-1:0]  error_limit_reg;

    asss_pkg::op_t                 op_reg;
    logic [asss_pkg::CHAR_W-1:0]   ch_reg;
    logic [asss_pkg::INDEX_W-1:0]  idx_reg;

    logic [ALPHABET-1:0] valid_reg;
    logic [VW-1:0]       vec_reg [NL];
    logic [VW-1:0]       prev_reg;
    logic [VW-1:0]       hit_vec_reg;
    logic [TW-1:0]       sel_reg;
    logic [LW-1:0]       lvl_reg;
    logic [PW-1:0]       pos_reg;
    logic                seen_reg;

    logic                          res_valid_reg;
    logic                          match_reg;
    logic [asss_pkg::START_W-1:0]  start_reg;
    logic                          first_reg;

    logic            req_fire;
    logic            ch_ok;
    logic            idx_ok;
    logic [AW-1:0]   ch_addr;
    logic [TW-1:0]   ram_rdata;
    logic [TW-1:0]   mask_cur;
    logic            ram_we;
    logic [TW-1:0]   ram_wdata;

    logic [VW-1:0]   lvl_old;
    logic [VW-1:0]   lvl_prev;
    logic [VW-1:0]   lvl_new;
    logic [LW-1:0]   k_sel;
    logic            lvl_last;

    logic            finish_go;
    logic            m_zero;
    logic            too_long;
    logic [VW-1:0]   hit_shift;
    logic            hit;
    logic [PW1-1:0]  pos_plus;
    logic [PW1-1:0]  m_ext;
    logic [PW1-1:0]  start_calc;
    logic [SW-1:0]   start_wide;

    assign cfg_ready = 1'b1;
    assign req_ready = (state_reg == ST_IDLE);
    assign req_fire  = req_valid && req_ready;

    assign ch_ok   = (int'(ch_reg) < ALPHABET);
    assign idx_ok  = (int'(idx_reg) < MAX_PATTERN);
    assign ch_addr = ch_reg[AW-1:0];

    asss_ram #(
        .WIDTH (TW),
        .DEPTH (ALPHABET)
    ) u_mask_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ch_addr),
        .wdata (ram_wdata),
        .re    (state_reg == ST_LOOK),
        .raddr (ch_addr),
        .rdata (ram_rdata)
    );

    // entries not loaded since the last clear read as all ones
    assign mask_cur  = (ch_ok && valid_reg[ch_addr]) ? ram_rdata : '1;
    assign ram_we    = (state_reg == ST_MERGE) && (op_reg == asss_pkg::OP_LOAD) && ch_ok && idx_ok;
    assign ram_wdata = mask_cur & ~(TW'(1) << idx_reg);

    // shared level unit: level 0 sees an all-ones lower neighbor
    assign lvl_old  = vec_reg[lvl_reg];
    assign lvl_prev = (lvl_reg == '0) ? '1 : prev_reg;
    assign lvl_new  = (lvl_prev & (lvl_old | VW'(sel_reg))) << 1;
    assign lvl_last = (lvl_reg == LW'(MAX_ERRORS));
    assign k_sel    = (int'(error_limit_reg) > MAX_ERRORS) ? LW'(MAX_ERRORS)
                                                           : LW'(error_limit_reg);

    assign finish_go  = (state_reg == ST_FINISH) && (!res_valid_reg || res_ready);
    assign m_zero     = (pattern_length_reg == '0);
    assign too_long   = (int'(pattern_length_reg) > MAX_PATTERN);
    assign hit_shift  = hit_vec_reg >> pattern_length_reg;
    assign hit        = m_zero || (!too_long && !hit_shift[0]);
    assign pos_plus   = {1'b0, pos_reg} + PW1'(1);
    assign m_ext      = PW1'(pattern_length_reg);
    assign start_calc = (m_zero || pos_plus < m_ext) ? '0 : pos_plus - m_ext;
    assign start_wide = SW'(start_calc[PW-1:0]);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire && (asss_pkg::op_t'(op) == asss_pkg::OP_LOAD ||
                                 asss_pkg::op_t'(op) == asss_pkg::OP_TEXT))
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                state_next = ST_MERGE;
            end
            ST_MERGE:
            begin
                state_next = (op_reg == asss_pkg::OP_TEXT) ? ST_LEVEL : ST_IDLE;
            end
            ST_LEVEL:
            begin
                if (lvl_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (finish_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            pattern_length_reg <= '0;
            error_limit_reg    <= '0;
            valid_reg          <= '0;
            lvl_reg            <= '0;
            pos_reg            <= '0;
            seen_reg           <= 1'b0;
            res_valid_reg      <= 1'b0;
            for (int i = 0; i < NL; i++)
            begin
                vec_reg[i] <= VEC_INIT;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == asss_pkg::CFG_PATTERN_LENGTH)
                begin
                    pattern_length_reg <= cfg_data[asss_pkg::LENGTH_W-1:0];
                end
                else if (cfg_index == asss_pkg::CFG_ERROR_LIMIT)
                begin
                    error_limit_reg <= cfg_data[asss_pkg::LIMIT_W-1:0];
                end
            end

            if (req_fire && asss_pkg::op_t'(op) == asss_pkg::OP_CLEAR)
            begin
                valid_reg <= '0;
            end
            if (req_fire && asss_pkg::op_t'(op) == asss_pkg::OP_START)
            begin
                pos_reg  <= '0;
                seen_reg <= 1'b0;
                for (int i = 0; i < NL; i++)
                begin
                    vec_reg[i] <= VEC_INIT;
                end
            end

            if (ram_we)
            begin
                valid_reg[ch_addr] <= 1'b1;
            end

            if (state_reg == ST_MERGE)
            begin
                lvl_reg <= '0;
            end
            if (state_reg == ST_LEVEL)
            begin
                vec_reg[lvl_reg] <= lvl_new;
                if (!lvl_last)
                begin
                    lvl_reg <= lvl_reg + LW'(1);
                end
            end

            if (finish_go)
            begin
                res_valid_reg <= 1'b1;
                if (pos_reg != POS_MAX)
                begin
                    pos_reg <= pos_reg + PW'(1);
                end
                if (hit)
                begin
                    seen_reg <= 1'b1;
                end
            end
            else if (res_valid_reg && res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            op_reg  <= asss_pkg::op_t'(op);
            ch_reg  <= char_value;
            idx_reg <= pattern_index;
        end
        if (state_reg == ST_MERGE)
        begin
            sel_reg <= mask_cur;
        end
        if (state_reg == ST_LEVEL)
        begin
            prev_reg <= lvl_old;
            if (lvl_reg == k_sel)
            begin
                hit_vec_reg <= lvl_new;
            end
        end
        if (finish_go)
        begin
            match_reg <= hit;
            start_reg <= hit ? start_wide[asss_pkg::START_W-1:0] : '0;
            first_reg <= hit && !seen_reg;
        end
    end

    assign res_valid       = res_valid_reg;
    assign match_found     = match_reg;
    assign start_position  = start_reg;
    assign first_match_res = first_reg;

    a_write_only_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_MERGE && op_reg == asss_pkg::OP_LOAD))
        else $error("mask table written outside a load request");

    a_level_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(lvl_reg) <= MAX_ERRORS)
        else $error("level counter past last level");

    a_finish_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        finish_go |=> res_valid)
        else $error("finished text byte gave no result");

    a_hit_marks_seen: assert property (@(posedge clk) disable iff (!rst_n)
        (finish_go && hit) |=> seen_reg)
        else $error("match not recorded as seen");

    a_no_match_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !match_found) |-> (start_position == '0 && !first_match_res))
        else $error("result fields set without a match");

endmodule
